/* rtl/core/otms_pkg.sv */
// Shared types and constants for the outlier threshold unit.
package otms_pkg;

    localparam int SMP_W       = 32;
    localparam int MULT_W      = 16;
    localparam int MULT_FRAC   = 8;
    localparam logic [MULT_W-1:0] MULT_RESET = 16'd768;
    localparam int SQ_W        = 64;
    localparam int PROD_W      = 50;
    localparam int TSUM_W      = 43;

    // Sequencer states of the threshold engine.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PIV,
        S_PIVW,
        S_SCAN,
        S_MDIV,
        S_MWAIT,
        S_VAR,
        S_VDIV,
        S_VWAIT,
        S_SQRT,
        S_PROD,
        S_ADD
    } t_state;

endpackage

/* rtl/core/otms_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module otms_div
    import otms_pkg::*;
#(
    parameter int DVD_W = 69,
    parameter int DVS_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;
    logic [DVS_W:0]   w_diff;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        w_trial = {r_rem, r_q[DVD_W-1]};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        w_diff  = w_trial - {1'b0, i_divisor};
    end

    // Control: count the steps and flag completion for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits replace the dividend bits as they shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

/* rtl/core/outlier_threshold_median_stddev_unit.sv */
// Outlier clamp threshold: median plus a multiple of the standard deviation.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_ready    i_sample, i_last
//   result    out        o_valid / i_ready    o_threshold, o_saturated
//   config    in         i_cfg_we             i_cfg_data (sigma multiplier)
//
// A beat with i_last starts the walk over the stored set in the sample memory:
// the median search, the mean division in the shared bit-serial divider, the
// variance pass, the variance division and the square root. A set of a single
// sample ends after the median search and gives that sample scaled by the multiplier.
// Reset clears the count, the running sum and the output valid flag; memory is not cleared.
// A stalled result holds in the output register while new samples are taken.
module outlier_threshold_median_stddev_unit
    import otms_pkg::*;
#(
    parameter int MAX_SAMPLES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SMP_W-1:0]  i_sample,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SMP_W-1:0]  o_threshold,
    output logic              o_saturated,
    input  logic              i_cfg_we,
    input  logic [MULT_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SMP_W + IDX_W;
    localparam int ACC_W = SQ_W + IDX_W;

    t_state r_state, n_state;

    logic [SMP_W-1:0]  r_mem [MAX_SAMPLES];
    logic [SMP_W-1:0]  r_rd;
    logic [IDX_W-1:0]  w_raddr;

    logic [MULT_W-1:0] r_mult;
    logic [CNT_W-1:0]  r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]  r_i, r_j, r_less, r_eq;
    logic              r_rv, r_av, r_sv;
    logic signed [SMP_W-1:0] r_piv, r_mean;
    logic [SMP_W-1:0]  r_ad;
    logic [SQ_W-1:0]   r_sq;
    logic [ACC_W-1:0]  r_acc;
    logic [SQ_W-1:0]   r_v, r_res, r_bit;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SMP_W-1:0]  r_base;
    logic              r_ovalid, r_osat;
    logic [SMP_W-1:0]  r_othr;

    logic              w_accept, w_out_free;
    logic [CNT_W-1:0]  w_rank;
    logic [CNT_W:0]    w_upper;
    logic              w_found, w_scan_end, w_var_end;
    logic [SUM_W-1:0]  w_sum_abs;
    logic              div_start, div_done;
    logic [ACC_W-1:0]  div_dvd, div_q;
    logic signed [SMP_W:0] w_diff;
    logic [SQ_W-1:0]   w_trial;
    logic signed [TSUM_W-1:0] w_total;
    logic              w_sat_hi, w_sat_lo;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;

    // Median test on the finished count scan.
    always_comb begin
        w_rank     = r_cnt >> 1;
        w_upper    = {1'b0, r_less} + {1'b0, r_eq};
        w_found    = (r_less <= w_rank) && ({1'b0, w_rank} < w_upper);
        w_scan_end = (r_j == r_cnt) && !r_rv;
        w_var_end  = (r_j == r_cnt) && !r_rv && !r_av && !r_sv;
        w_sum_abs  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    end

    // Variance pass difference, square root trial and final sum.
    always_comb begin
        w_diff  = $signed({r_rd[SMP_W-1], r_rd}) - $signed({r_mean[SMP_W-1], r_mean});
        w_trial = r_res + r_bit;
        w_total = TSUM_W'(r_base) + TSUM_W'(r_prod >>> MULT_FRAC);
        w_sat_hi = !w_total[TSUM_W-1] && (w_total[TSUM_W-2:SMP_W-1] != '0);
        w_sat_lo = w_total[TSUM_W-1] && (w_total[TSUM_W-2:SMP_W-1] != '1);
    end

    // Sample memory: written during loading, read one entry per cycle afterwards.
    assign w_raddr = (r_state == S_PIV) ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_accept && (r_cnt < CNT_W'(MAX_SAMPLES))) begin
            r_mem[r_cnt[IDX_W-1:0]] <= i_sample;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Shared divider for the mean and the variance.
    assign div_start = (r_state == S_MDIV) || (r_state == S_VDIV);
    assign div_dvd   = (r_state == S_MDIV) ? ACC_W'(w_sum_abs) : r_acc;

    otms_div #(
        .DVD_W(ACC_W),
        .DVS_W(CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake.
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && i_last) begin
                    n_state = S_PIV;
                end
            end
            S_PIV:   n_state = S_PIVW;
            S_PIVW:  n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan_end) begin
                    if (!w_found) begin
                        n_state = S_PIV;
                    end else if (r_cnt == CNT_W'(1)) begin
                        n_state = S_PROD;
                    end else begin
                        n_state = S_MDIV;
                    end
                end
            end
            S_MDIV:  n_state = S_MWAIT;
            S_MWAIT: begin
                if (div_done) begin
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                if (w_var_end) begin
                    n_state = S_VDIV;
                end
            end
            S_VDIV:  n_state = S_VWAIT;
            S_VWAIT: begin
                if (div_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_bit == '0) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:  n_state = S_ADD;
            S_ADD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers: multiplier, count, running sum and the result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult   <= MULT_RESET;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mult <= i_cfg_data;
            end
            if (w_accept && (r_cnt < CNT_W'(MAX_SAMPLES))) begin
                r_cnt <= r_cnt + 1'b1;
                r_sum <= r_sum + SUM_W'($signed(i_sample));
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == S_ADD) && w_out_free) begin
                r_ovalid <= 1'b1;
                r_cnt    <= '0;
                r_sum    <= '0;
            end
        end
    end

    // Walk datapath: median search, variance pass, square root, product and saturating final sum.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_i <= '0;
            end
            S_PIVW: begin
                r_piv  <= r_rd;
                r_j    <= '0;
                r_less <= '0;
                r_eq   <= '0;
                r_rv   <= 1'b0;
            end
            S_SCAN: begin
                r_rv <= (r_j != r_cnt);
                if (r_j != r_cnt) begin
                    r_j <= r_j + 1'b1;
                end
                if (r_rv) begin
                    if ($signed(r_rd) < r_piv) begin
                        r_less <= r_less + 1'b1;
                    end else if ($signed(r_rd) == r_piv) begin
                        r_eq <= r_eq + 1'b1;
                    end
                end
                if (w_scan_end) begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_MWAIT: begin
                r_mean <= r_sum[SUM_W-1] ? SMP_W'(-div_q[SMP_W-1:0]) : div_q[SMP_W-1:0];
                r_j    <= '0;
                r_rv   <= 1'b0;
                r_av   <= 1'b0;
                r_sv   <= 1'b0;
                r_acc  <= '0;
            end
            S_VAR: begin
                r_rv <= (r_j != r_cnt);
                if (r_j != r_cnt) begin
                    r_j <= r_j + 1'b1;
                end
                r_av <= r_rv;
                r_ad <= w_diff[SMP_W] ? SMP_W'(-w_diff) : w_diff[SMP_W-1:0];
                r_sv <= r_av;
                r_sq <= r_ad * r_ad;
                if (r_sv) begin
                    r_acc <= r_acc + ACC_W'(r_sq);
                end
            end
            S_VWAIT: begin
                r_v   <= div_q[SQ_W-1:0];
                r_res <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
            end
            S_SQRT: begin
                if (r_bit != '0) begin
                    if (r_v >= w_trial) begin
                        r_v   <= r_v - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            S_PROD: begin
                if (r_cnt == CNT_W'(1)) begin
                    r_prod <= PROD_W'(r_piv * $signed({1'b0, r_mult}));
                    r_base <= '0;
                end else begin
                    r_prod <= $signed(PROD_W'(r_mult * r_res[SMP_W-1:0]));
                    r_base <= r_piv;
                end
            end
            S_ADD: begin
                if (w_out_free) begin
                    r_osat <= w_sat_hi || w_sat_lo;
                    if (w_sat_hi) begin
                        r_othr <= {1'b0, {(SMP_W-1){1'b1}}};
                    end else if (w_sat_lo) begin
                        r_othr <= {1'b1, {(SMP_W-1){1'b0}}};
                    end else begin
                        r_othr <= w_total[SMP_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_threshold = r_othr;
    assign o_saturated = r_osat;

endmodule

/* rtl/core/otms_chk.sv */
// Port-level checker for the outlier threshold unit, with its bind.
module otms_chk
    import otms_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_last,
    input logic              o_valid,
    input logic              i_ready,
    input logic [SMP_W-1:0]  o_threshold,
    input logic              o_saturated
);

    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_threshold) && $stable(o_saturated))
        else $error("result beat changed while stalled");

    // A saturated result sits at one of the two range limits.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_threshold == 32'h7fffffff || o_threshold == 32'h80000000)
        else $error("saturated flag without a limit value");

    // Closing a set makes the input side busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last |=> !o_ready)
        else $error("input taken while the set is processed");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind outlier_threshold_median_stddev_unit otms_chk u_otms_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_last      (i_last),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_threshold (o_threshold),
    .o_saturated (o_saturated)
);
